// ===== src/fpsd_pkg.sv =====
// Shared types and constants for the four-prime sum decomposer.
// No dependencies; every other file in src/ but fpsd_ram uses this package.
`default_nettype none

package fpsd_pkg;

   // Size of the composite map: numbers 0 .. MAX_N-1 are covered
   localparam int MAX_N   = 65536;
   localparam int MAP_AW  = $clog2(MAX_N);
   // Sieve counters: wide enough for i*i and j+2i just past the map end
   localparam int SV_CW   = MAP_AW + 2;
   // Init sweep counter: must hold MAX_N-1
   localparam int INIT_CW = MAP_AW + 1;

   // Word field widths
   localparam int TGT_W   = 16;
   localparam int SMALL_W = 2;

   // Arithmetic constants of the decomposition
   localparam int MIN_TARGET  = 8;
   localparam int EVEN_SUB    = 4;
   localparam int ODD_SUB     = 5;
   localparam int FIRST_PRIME = 2;
   localparam int EVEN_SECOND = 2;
   localparam int ODD_SECOND  = 3;
   localparam int FIRST_CAND  = 2;
   localparam int FIRST_ODD   = 3;

   typedef enum logic [2:0] {
      SV_INIT,
      SV_READ,
      SV_CHECK,
      SV_MARK,
      SV_DONE
   } sieve_state_type;

   typedef enum logic [1:0] {
      SR_IDLE,
      SR_SCAN,
      SR_HOLD
   } search_state_type;

   // Write port of the composite map, driven by the sieve
   typedef struct packed {
      logic              we;
      logic [MAP_AW-1:0] addr;
      logic              data;
   } map_wr_type;

endpackage

`default_nettype wire

// ===== src/fpsd_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on fpsd_pkg for the field widths.
`default_nettype none

interface fpsd_req_if;
   logic                        valid;
   logic                        ready;
   logic [fpsd_pkg::TGT_W-1:0]  target;

   modport source (output valid, output target, input ready);
   modport sink   (input valid, input target, output ready);
endinterface

interface fpsd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          possible;
   logic [fpsd_pkg::SMALL_W-1:0]  first_prime;
   logic [fpsd_pkg::SMALL_W-1:0]  second_prime;
   logic [fpsd_pkg::TGT_W-1:0]    third_prime;
   logic [fpsd_pkg::TGT_W-1:0]    fourth_prime;

   modport source (output valid, output possible, output first_prime, output second_prime,
                   output third_prime, output fourth_prime, input ready);
   modport sink   (input valid, input possible, input first_prime, input second_prime,
                   input third_prime, input fourth_prime, output ready);
endinterface

`default_nettype wire

// ===== src/fpsd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module fpsd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/fpsd_sieve.sv =====
// Builds the composite map after reset: an init sweep, then a sieve of
// Eratosthenes over odd primes. Depends on fpsd_pkg.
`default_nettype none

module fpsd_sieve (
   input  wire logic                        clock,
   input  wire logic                        reset,
   output      fpsd_pkg::map_wr_type        map_wr,
   output      logic [fpsd_pkg::MAP_AW-1:0] raddr,
   input  wire logic                        rdata,
   output      logic                        done
);

   import fpsd_pkg::*;

   sieve_state_type      state_ff, state_in;
   logic [INIT_CW-1:0]   k_ff, k_in;
   logic [SV_CW-1:0]     i_ff, i_in;
   logic [SV_CW-1:0]     sq_ff, sq_in;
   logic [SV_CW-1:0]     j_ff, j_in;
   logic [SV_CW-1:0]     j_next;
   logic [SV_CW-1:0]     sq_next;
   logic                 last_init;
   logic                 sq_past;
   logic                 j_past;

   assign last_init = (k_ff == INIT_CW'(MAX_N - 1));
   assign sq_past   = (sq_ff >= SV_CW'(MAX_N));
   assign j_next    = j_ff + (i_ff << 1);
   assign j_past    = (j_next >= SV_CW'(MAX_N));
   // (i+2)^2 = i^2 + 4i + 4
   assign sq_next   = sq_ff + (i_ff << 2) + SV_CW'(4);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SV_INIT: begin
            if (last_init) state_in = SV_READ;
         end
         SV_READ: begin
            state_in = sq_past ? SV_DONE : SV_CHECK;
         end
         SV_CHECK: begin
            state_in = rdata ? SV_READ : SV_MARK;
         end
         SV_MARK: begin
            if (j_past) state_in = SV_READ;
         end
         SV_DONE: begin
            state_in = SV_DONE;
         end
         default: begin
            state_in = SV_INIT;
         end
      endcase
   end

   // Counters and map port
   always_comb begin
      k_in         = k_ff;
      i_in         = i_ff;
      sq_in        = sq_ff;
      j_in         = j_ff;
      map_wr.we    = 1'b0;
      map_wr.addr  = MAP_AW'(j_ff);
      map_wr.data  = 1'b1;
      raddr        = MAP_AW'(i_ff);
      case (state_ff)
         SV_INIT: begin
            // 0 and 1 are marked, and every even number from 4 up
            map_wr.we   = 1'b1;
            map_wr.addr = MAP_AW'(k_ff);
            map_wr.data = (k_ff < INIT_CW'(2)) ||
                          (!k_ff[0] && (k_ff >= INIT_CW'(4)));
            k_in        = k_ff + INIT_CW'(1);
            i_in        = SV_CW'(FIRST_ODD);
            sq_in       = SV_CW'(FIRST_ODD * FIRST_ODD);
         end
         SV_CHECK: begin
            if (rdata) begin
               i_in  = i_ff + SV_CW'(2);
               sq_in = sq_next;
            end else begin
               j_in  = sq_ff;
            end
         end
         SV_MARK: begin
            map_wr.we = 1'b1;
            j_in      = j_next;
            if (j_past) begin
               i_in  = i_ff + SV_CW'(2);
               sq_in = sq_next;
            end
         end
         default: begin
         end
      endcase
   end

   assign done = (state_ff == SV_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SV_INIT;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
      i_ff  <= i_in;
      sq_ff <= sq_in;
      j_ff  <= j_in;
   end

endmodule

`default_nettype wire

// ===== src/fpsd_search.sv =====
// Per-word search: fixes the first two primes, then scans candidates p with
// two map reads a cycle (p and m-p). Depends on fpsd_pkg and fpsd_if.
`default_nettype none

module fpsd_search (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        map_done,
   fpsd_req_if.sink                         req,
   fpsd_rsp_if.source                       rsp,
   output      logic [fpsd_pkg::MAP_AW-1:0] raddr_a,
   output      logic [fpsd_pkg::MAP_AW-1:0] raddr_b,
   input  wire logic                        rdata_a,
   input  wire logic                        rdata_b
);

   import fpsd_pkg::*;

   search_state_type     state_ff, state_in;
   // Issue stage
   logic [TGT_W-1:0]     p_ff, p_in;
   logic [TGT_W-1:0]     q_ff, q_in;
   logic [TGT_W-1:0]     half_ff, half_in;
   logic [SMALL_W-1:0]   second_ff, second_in;
   // Read-data stage
   logic                 pv_ff, pv_in;
   logic [TGT_W-1:0]     pd_ff;
   logic [TGT_W-1:0]     qd_ff;
   logic                 pin_ff;
   logic                 qin_ff;
   // Finished result waiting for the output register
   logic                 rposs_ff, rposs_in;
   logic [TGT_W-1:0]     rthird_ff, rthird_in;
   logic [TGT_W-1:0]     rfourth_ff, rfourth_in;
   // Output register
   logic                 ov_ff, ov_in;
   logic                 oposs_ff;
   logic [SMALL_W-1:0]   ofirst_ff;
   logic [SMALL_W-1:0]   osecond_ff;
   logic [TGT_W-1:0]     othird_ff;
   logic [TGT_W-1:0]     ofourth_ff;

   logic                 accept;
   logic                 small_tgt;
   logic [TGT_W-1:0]     rem;
   logic                 issue;
   logic                 hit;
   logic                 drained;
   logic                 load_out;

   assign req.ready = map_done && (state_ff == SR_IDLE);
   assign accept    = req.valid && req.ready;
   assign small_tgt = (req.target < TGT_W'(MIN_TARGET));
   assign rem       = req.target - (req.target[0] ? TGT_W'(ODD_SUB) : TGT_W'(EVEN_SUB));

   assign issue     = (p_ff <= half_ff);
   assign hit       = pv_ff && pin_ff && qin_ff && !rdata_a && !rdata_b;
   assign drained   = !issue && !pv_ff;
   assign load_out  = (state_ff == SR_HOLD) && (!ov_ff || rsp.ready);

   assign raddr_a   = MAP_AW'(p_ff);
   assign raddr_b   = MAP_AW'(q_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SR_IDLE: begin
            if (accept) state_in = small_tgt ? SR_HOLD : SR_SCAN;
         end
         SR_SCAN: begin
            if (hit || drained) state_in = SR_HOLD;
         end
         SR_HOLD: begin
            if (load_out) state_in = SR_IDLE;
         end
         default: begin
            state_in = SR_IDLE;
         end
      endcase
   end

   // Datapath
   always_comb begin
      p_in       = p_ff;
      q_in       = q_ff;
      half_in    = half_ff;
      second_in  = second_ff;
      pv_in      = 1'b0;
      rposs_in   = rposs_ff;
      rthird_in  = rthird_ff;
      rfourth_in = rfourth_ff;
      case (state_ff)
         SR_IDLE: begin
            p_in       = TGT_W'(FIRST_CAND);
            q_in       = rem - TGT_W'(FIRST_CAND);
            half_in    = rem >> 1;
            second_in  = req.target[0] ? SMALL_W'(ODD_SECOND) : SMALL_W'(EVEN_SECOND);
            rposs_in   = 1'b0;
            rthird_in  = '0;
            rfourth_in = '0;
         end
         SR_SCAN: begin
            pv_in = issue && !hit;
            if (issue) begin
               p_in = p_ff + TGT_W'(1);
               q_in = q_ff - TGT_W'(1);
            end
            if (hit) begin
               rposs_in   = 1'b1;
               rthird_in  = pd_ff;
               rfourth_in = qd_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: holds while the sink stalls
   always_comb begin
      ov_in = ov_ff;
      if (rsp.ready) ov_in = 1'b0;
      if (load_out) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SR_IDLE;
         pv_ff    <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= pv_in;
         ov_ff    <= ov_in;
      end
      p_ff       <= p_in;
      q_ff       <= q_in;
      half_ff    <= half_in;
      second_ff  <= second_in;
      pd_ff      <= p_ff;
      qd_ff      <= q_ff;
      pin_ff     <= (32'(p_ff) < MAX_N);
      qin_ff     <= (32'(q_ff) < MAX_N);
      rposs_ff   <= rposs_in;
      rthird_ff  <= rthird_in;
      rfourth_ff <= rfourth_in;
      if (load_out) begin
         oposs_ff   <= rposs_ff;
         ofirst_ff  <= rposs_ff ? SMALL_W'(FIRST_PRIME) : '0;
         osecond_ff <= rposs_ff ? second_ff : '0;
         othird_ff  <= rthird_ff;
         ofourth_ff <= rfourth_ff;
      end
   end

   assign rsp.valid        = ov_ff;
   assign rsp.possible     = oposs_ff;
   assign rsp.first_prime  = ofirst_ff;
   assign rsp.second_prime = osecond_ff;
   assign rsp.third_prime  = othird_ff;
   assign rsp.fourth_prime = ofourth_ff;

endmodule

`default_nettype wire

// ===== src/four_prime_sum_decomposer.sv =====
// Four-prime sum decomposer. After reset the block writes the initial
// composite map over all MAX_N addresses and then sieves odd primes below
// sqrt(MAX_N); req.ready stays low until then. For each request word the
// scan reads the map at p and at m-p in the same cycle from two copies of
// the map, one candidate a cycle; targets below 8 skip the scan. Most
// targets find p within a few candidates. A finished word sits in an
// output register, so a new request is taken while the previous response
// waits.
// Depends on fpsd_pkg, fpsd_if, fpsd_ram, fpsd_sieve and fpsd_search.
`default_nettype none

module four_prime_sum_decomposer (
   input  wire logic  clock,
   input  wire logic  reset,
   fpsd_req_if.sink   req,
   fpsd_rsp_if.source rsp
);

   import fpsd_pkg::*;

   map_wr_type          map_wr;
   logic [MAP_AW-1:0]   sv_raddr;
   logic [MAP_AW-1:0]   sr_raddr_a;
   logic [MAP_AW-1:0]   sr_raddr_b;
   logic [MAP_AW-1:0]   raddr_a;
   logic                rdata_a;
   logic                rdata_b;
   logic                map_done;

   fpsd_sieve u_sieve (
      .clock  (clock),
      .reset  (reset),
      .map_wr (map_wr),
      .raddr  (sv_raddr),
      .rdata  (rdata_a),
      .done   (map_done)
   );

   fpsd_search u_search (
      .clock    (clock),
      .reset    (reset),
      .map_done (map_done),
      .req      (req),
      .rsp      (rsp),
      .raddr_a  (sr_raddr_a),
      .raddr_b  (sr_raddr_b),
      .rdata_a  (rdata_a),
      .rdata_b  (rdata_b)
   );

   // Port A is shared: the sieve owns it until the map is built
   assign raddr_a = map_done ? sr_raddr_a : sv_raddr;

   // Two identical copies of the map give two reads a cycle
   fpsd_ram #(
      .WIDTH (1),
      .DEPTH (MAX_N)
   ) u_map_a (
      .clock (clock),
      .we    (map_wr.we),
      .waddr (map_wr.addr),
      .wdata (map_wr.data),
      .raddr (raddr_a),
      .rdata (rdata_a)
   );

   fpsd_ram #(
      .WIDTH (1),
      .DEPTH (MAX_N)
   ) u_map_b (
      .clock (clock),
      .we    (map_wr.we),
      .waddr (map_wr.addr),
      .wdata (map_wr.data),
      .raddr (sr_raddr_b),
      .rdata (rdata_b)
   );

endmodule

`default_nettype wire
